// ===== design/pfe_pkg.sv =====
// ============================================================================
// pfe_pkg
// Types, constants and helper functions shared by the format engine modules.
// ============================================================================
package pfe_pkg;

    localparam int MAX_FIELD   = 60;
    localparam int LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // Bit positions in the spec flags.
    localparam int F_LEFT = 0;
    localparam int F_PLUS = 1;
    localparam int F_ALT  = 2;
    localparam int F_ZERO = 3;
    localparam int F_PREC = 4;
    localparam int F_H    = 5;
    localparam int F_L    = 6;
    localparam int F_LL   = 7;

    typedef struct packed {
        logic        operation;
        logic [7:0]  format_char;
        logic [31:0] argument_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        last_of_run;
        logic        finished;
        logic [15:0] total_length;
    } t_out_item;

    typedef enum logic [10:0] {
        PH_LIT        = 11'b000_0000_0001,
        PH_FLAGS      = 11'b000_0000_0010,
        PH_WIDTH      = 11'b000_0000_0100,
        PH_WIDTH_DONE = 11'b000_0000_1000,
        PH_PREC_START = 11'b000_0001_0000,
        PH_PREC       = 11'b000_0010_0000,
        PH_PREC_DONE  = 11'b000_0100_0000,
        PH_MODS       = 11'b000_1000_0000,
        PH_ARG_WIDTH  = 11'b001_0000_0000,
        PH_ARG_PREC   = 11'b010_0000_0000,
        PH_ARG_VALUE  = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] flags;
        logic [7:0] pfx;
        logic [5:0] width;
        logic [5:0] prec;
        logic [7:0] conv;
    } t_spec;

    // What the parser asks of the formatter for one accepted item.
    typedef struct packed {
        logic        emit;
        logic [7:0]  ch;
        logic        fin;
        logic        start;
        t_spec       spec;
    } t_parse_out;

    function automatic logic [5:0] clamp_field(input logic [31:0] v);
        return (v > 32'(MAX_FIELD)) ? 6'(MAX_FIELD) : v[5:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        if (d < 4'd10) return 8'h30 + {4'b0, d};
        else if (upper) return 8'h37 + {4'b0, d};
        else return 8'h57 + {4'b0, d};
    endfunction

endpackage

// ===== design/pfe_parser.sv =====
// ============================================================================
// pfe_parser
// Format string parser: literal text, flags, width, precision, modifiers and conversion.
// ============================================================================
module pfe_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  pfe_pkg::t_in_item  i_item,
    output pfe_pkg::t_parse_out o_res
);

    pfe_pkg::t_phase r_phase, n_phase;
    pfe_pkg::t_spec  r_spec,  n_spec;

    logic [7:0]  c;
    logic [31:0] w, wneg;
    logic        dig;
    logic        enter, modconv;
    logic [9:0]  wacc, pacc;

    always_comb begin
        c     = i_item.format_char;
        w     = i_item.argument_word;
        wneg  = 32'd0 - w;
        dig   = (c >= "0") && (c <= "9");
        wacc  = 10'(r_spec.width) * 10'd10 + 10'(c - "0");
        pacc  = 10'(r_spec.prec) * 10'd10 + 10'(c - "0");
        n_phase = r_phase;
        n_spec  = r_spec;
        enter   = 1'b0;
        modconv = 1'b0;
        o_res       = '0;
        o_res.spec  = r_spec;
        if (!i_item.operation) begin
            unique case (r_phase)
                pfe_pkg::PH_LIT: begin
                    if (c == 8'd0) begin
                        o_res.emit = 1'b1;
                        o_res.fin  = 1'b1;
                    end else if (c != "%") begin
                        o_res.emit = 1'b1;
                        o_res.ch   = c;
                    end else begin
                        n_spec  = '0;
                        n_phase = pfe_pkg::PH_FLAGS;
                    end
                end
                pfe_pkg::PH_FLAGS: begin
                    if (c == "-") n_spec.flags[pfe_pkg::F_LEFT] = 1'b1;
                    else if (c == "+") n_spec.flags[pfe_pkg::F_PLUS] = 1'b1;
                    else if (c == " ") n_spec.pfx = " ";
                    else if (c == "#") n_spec.flags[pfe_pkg::F_ALT] = 1'b1;
                    else if (c == "0") n_spec.flags[pfe_pkg::F_ZERO] = 1'b1;
                    else if (c == "*") n_phase = pfe_pkg::PH_ARG_WIDTH;
                    else if (dig) begin
                        n_spec.width = pfe_pkg::clamp_field(32'(c - "0"));
                        n_phase = pfe_pkg::PH_WIDTH;
                    end else if (c == ".") n_phase = pfe_pkg::PH_PREC_START;
                    else enter = 1'b1;
                end
                pfe_pkg::PH_WIDTH: begin
                    if (dig) n_spec.width = pfe_pkg::clamp_field(32'(wacc));
                    else if (c == ".") n_phase = pfe_pkg::PH_PREC_START;
                    else enter = 1'b1;
                end
                pfe_pkg::PH_WIDTH_DONE: begin
                    if (c == ".") n_phase = pfe_pkg::PH_PREC_START;
                    else enter = 1'b1;
                end
                pfe_pkg::PH_PREC_START: begin
                    if (c == "*") n_phase = pfe_pkg::PH_ARG_PREC;
                    else if (dig) begin
                        n_spec.prec = pfe_pkg::clamp_field(32'(c - "0"));
                        n_phase = pfe_pkg::PH_PREC;
                    end else begin
                        n_spec.flags[pfe_pkg::F_PREC] = 1'b1;
                        enter = 1'b1;
                    end
                end
                pfe_pkg::PH_PREC: begin
                    if (dig) n_spec.prec = pfe_pkg::clamp_field(32'(pacc));
                    else begin
                        n_spec.flags[pfe_pkg::F_PREC] = 1'b1;
                        enter = 1'b1;
                    end
                end
                pfe_pkg::PH_PREC_DONE: enter = 1'b1;
                pfe_pkg::PH_MODS: modconv = 1'b1;
                default: ;
            endcase
            if (enter) begin
                if (n_spec.flags[pfe_pkg::F_LEFT]) n_spec.flags[pfe_pkg::F_ZERO] = 1'b0;
                n_phase = pfe_pkg::PH_MODS;
                modconv = 1'b1;
            end
            if (modconv) begin
                if (c == "h") n_spec.flags[pfe_pkg::F_H] = 1'b1;
                else if (c == "l") n_spec.flags[pfe_pkg::F_L] = 1'b1;
                else if (c == "L") n_spec.flags[pfe_pkg::F_LL] = 1'b1;
                else if (c == "p") begin
                    n_spec.prec = 6'd8;
                    n_spec.flags[pfe_pkg::F_L]    = 1'b1;
                    n_spec.flags[pfe_pkg::F_PREC] = 1'b1;
                    n_spec.conv = c;
                    n_phase = pfe_pkg::PH_ARG_VALUE;
                end else if (c == "d" || c == "i" || c == "u" || c == "o" ||
                             c == "x" || c == "X" || c == "c") begin
                    n_spec.conv = c;
                    n_phase = pfe_pkg::PH_ARG_VALUE;
                end else if (c == "%") begin
                    o_res.emit = 1'b1;
                    o_res.ch   = "%";
                    n_phase    = pfe_pkg::PH_LIT;
                end else begin
                    o_res.emit = 1'b1;
                    o_res.fin  = 1'b1;
                    n_phase    = pfe_pkg::PH_LIT;
                end
            end
            if (o_res.fin) n_phase = pfe_pkg::PH_LIT;
        end else begin
            unique case (r_phase)
                pfe_pkg::PH_ARG_WIDTH: begin
                    if (w[31]) begin
                        n_spec.flags[pfe_pkg::F_LEFT] = 1'b1;
                        n_spec.width = pfe_pkg::clamp_field(wneg);
                    end else begin
                        n_spec.width = pfe_pkg::clamp_field(w);
                    end
                    n_phase = pfe_pkg::PH_WIDTH_DONE;
                end
                pfe_pkg::PH_ARG_PREC: begin
                    if (w[31]) n_spec.prec = 6'd0;
                    else begin
                        n_spec.prec = pfe_pkg::clamp_field(w);
                        n_spec.flags[pfe_pkg::F_PREC] = 1'b1;
                    end
                    n_phase = pfe_pkg::PH_PREC_DONE;
                end
                pfe_pkg::PH_ARG_VALUE: begin
                    o_res.start = 1'b1;
                    n_phase = pfe_pkg::PH_LIT;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pfe_pkg::PH_LIT;
            r_spec  <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_spec  <= n_spec;
        end
    end

endmodule

// ===== design/printf_format_engine_top.sv =====
// ============================================================================
// printf_format_engine_top
// Printf-style formatter: format bytes and argument words in, characters out.
// ============================================================================
// Usage: the input channel (i_in_valid / o_in_ready / i_in_item) carries one
// item per handshake, either a format byte or a 32-bit argument word. The
// output channel (o_out_valid / i_out_ready / o_out_item) carries characters,
// each with the running length; last_of_run marks the final character of an
// item and finished marks the terminating zero.
// A literal byte, "%%" or the end of a string gives one character and the
// block is ready again once the output register is free or being read.
// A numeric argument is converted one step per cycle by a shared shift unit:
// decimal takes 32 double-dabble shifts, then one digit per step plus a final
// step to see the end; hex and octal take one digit per step plus a final step.
// Then come a setup step and the emitted characters (up to 62), one at a time
// through the single output register. Items that produce nothing leave the
// sequencer idle. The input is not ready while a field is being converted or
// emitted. When the receiver stalls, the output register holds its character
// and the emit sequencer waits. Synchronous reset returns to literal text with
// a length of zero; the digit buffer needs no clearing.
// ============================================================================
module printf_format_engine_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pfe_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pfe_pkg::t_out_item o_out_item
);

    typedef enum logic [4:0] {
        FS_IDLE   = 5'b00001,
        FS_DABBLE = 5'b00010,
        FS_DIGITS = 5'b00100,
        FS_SETUP  = 5'b01000,
        FS_EMIT   = 5'b10000
    } t_fstate;

    t_fstate r_state, n_state;
    logic    take, ld;
    pfe_pkg::t_parse_out pres;

    pfe_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_item),
        .o_res   (pres)
    );

    // Field registers.
    logic [31:0] r_bin,  n_bin;
    logic [39:0] r_acc,  n_acc;
    logic [4:0]  r_step, n_step;
    logic        r_s4, n_s4, r_upper, n_upper, r_octalt, n_octalt;
    logic        r_zfen, n_zfen, r_left, n_left;
    logic [5:0]  r_prec, n_prec, r_width, n_width;
    logic [1:0]  r_plen, n_plen;
    logic [7:0]  r_pc0, n_pc0, r_pc1, n_pc1;
    logic [3:0]  r_nd, n_nd;
    logic [6:0]  r_zf, n_zf, r_cnt, n_cnt, r_pad, n_pad, r_tot, n_tot;
    logic [6:0]  r_k, n_k;
    logic [7:0]  r_buf [16];
    logic        buf_we;
    logic [7:0]  buf_wd;
    logic [3:0]  buf_wa;

    logic [pfe_pkg::LENGTH_BITS-1:0] r_len, n_len;
    logic        r_ovalid, n_ovalid;
    pfe_pkg::t_out_item r_oitem, n_oitem;

    // Setup intermediates.
    pfe_pkg::t_spec sp;
    logic [31:0] v, mag;
    logic        is_c, is_o, is_hex, is_u, is_dec, neg;
    logic [7:0]  pfx;
    logic [7:0]  adj;
    logic signed [7:0] pe;
    logic [39:0] bcd;
    logic [3:0]  dnib;
    logic [6:0]  zfc, cntc, j, d;
    logic [3:0]  bidx;
    logic [7:0]  ech;
    logic        load;
    logic [7:0]  lch;
    logic        lfin, llast;

    assign take = i_in_valid && o_in_ready;
    assign ld   = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == FS_IDLE) && ld;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    always_comb begin
        sp     = pres.spec;
        is_c   = sp.conv == "c";
        is_o   = sp.conv == "o";
        is_hex = sp.conv == "x" || sp.conv == "X" || sp.conv == "p";
        is_u   = sp.conv == "u";
        is_dec = !is_c && !is_o && !is_hex;
        v = i_in_item.argument_word;
        if (sp.flags[pfe_pkg::F_H]) begin
            if (is_dec && !is_u) v = {{16{v[15]}}, v[15:0]};
            else v = {16'd0, v[15:0]};
        end
        neg = is_dec && !is_u && v[31];
        mag = neg ? (32'd0 - v) : v;
        if (is_u) pfx = 8'd0;
        else if (neg) pfx = "-";
        else if (sp.flags[pfe_pkg::F_PLUS]) pfx = "+";
        else pfx = sp.pfx;
        if (is_hex) adj = sp.flags[pfe_pkg::F_ALT] ? 8'd2 : 8'd0;
        else if (is_dec) adj = (pfx != 8'd0) ? 8'd1 : 8'd0;
        else adj = 8'd0;
        pe = signed'({2'b00, sp.prec});
        if (!sp.flags[pfe_pkg::F_PREC]) begin
            if (sp.flags[pfe_pkg::F_ZERO]) pe = signed'({2'b00, sp.width} - adj);
            if (pe <= 8'sd0) pe = 8'sd1;
        end

        // Double-dabble adjust for one shift step.
        for (int i = 0; i < 10; i++) begin
            bcd[i*4 +: 4] = (r_acc[i*4 +: 4] >= 4'd5) ? r_acc[i*4 +: 4] + 4'd3
                                                       : r_acc[i*4 +: 4];
        end
        dnib = r_s4 ? r_acc[3:0] : {1'b0, r_acc[2:0]};

        zfc  = (r_zfen && (7'(r_prec) > 7'(r_nd))) ? 7'(r_prec) - 7'(r_nd) : 7'd0;
        cntc = 7'(r_plen) + zfc + 7'(r_nd);

        // Character at position k of the field.
        j = r_left ? r_k : r_k - r_pad;
        d = j - 7'(r_plen) - r_zf;
        bidx = r_nd - 4'd1 - d[3:0];
        if (!r_left && (r_k < r_pad)) ech = " ";
        else if (r_left && (j >= r_cnt)) ech = " ";
        else if (j < 7'(r_plen)) ech = (j == 7'd0) ? r_pc0 : r_pc1;
        else if (j < 7'(r_plen) + r_zf) ech = "0";
        else ech = r_buf[bidx];

        n_state = r_state;
        n_bin = r_bin;   n_acc = r_acc;   n_step = r_step; n_s4 = r_s4;
        n_upper = r_upper; n_octalt = r_octalt; n_zfen = r_zfen; n_left = r_left;
        n_prec = r_prec; n_width = r_width; n_plen = r_plen;
        n_pc0 = r_pc0;   n_pc1 = r_pc1;   n_nd = r_nd;
        n_zf = r_zf;     n_cnt = r_cnt;   n_pad = r_pad;   n_tot = r_tot;
        n_k = r_k;
        buf_we = 1'b0;
        buf_wd = 8'd0;
        buf_wa = r_nd;
        load = 1'b0;
        lch = 8'd0;
        lfin = 1'b0;
        llast = 1'b1;

        unique case (r_state)
            FS_IDLE: begin
                if (take && pres.emit) begin
                    load = 1'b1;
                    lch  = pres.ch;
                    lfin = pres.fin;
                end
                if (take && pres.start) begin
                    n_left   = sp.flags[pfe_pkg::F_LEFT];
                    n_width  = sp.width;
                    n_prec   = 6'(pe);
                    n_zfen   = !is_c;
                    n_upper  = sp.conv != "x";
                    n_octalt = is_o && sp.flags[pfe_pkg::F_ALT];
                    n_pc0    = is_hex ? 8'h30 : pfx;
                    n_pc1    = sp.conv;
                    n_plen   = is_hex ? (sp.flags[pfe_pkg::F_ALT] ? 2'd2 : 2'd0)
                             : (is_dec && pfx != 8'd0) ? 2'd1 : 2'd0;
                    n_nd     = 4'd0;
                    n_step   = 5'd0;
                    if (is_c) begin
                        buf_we  = 1'b1;
                        buf_wa  = 4'd0;
                        buf_wd  = i_in_item.argument_word[7:0];
                        n_nd    = 4'd1;
                        n_state = FS_SETUP;
                    end else if (is_dec) begin
                        n_bin   = mag;
                        n_acc   = 40'd0;
                        n_state = FS_DABBLE;
                    end else begin
                        n_acc   = {8'd0, mag};
                        n_s4    = is_hex;
                        n_state = FS_DIGITS;
                    end
                end
            end
            FS_DABBLE: begin
                n_acc  = {bcd[38:0], r_bin[31]};
                n_bin  = {r_bin[30:0], 1'b0};
                n_step = r_step + 5'd1;
                if (r_step == 5'd31) begin
                    n_s4    = 1'b1;
                    n_state = FS_DIGITS;
                end
            end
            FS_DIGITS: begin
                if (r_acc == 40'd0) begin
                    if (r_octalt && r_nd != 4'd0) begin
                        buf_we = 1'b1;
                        buf_wd = 8'h30;
                        n_nd   = r_nd + 4'd1;
                    end
                    n_state = FS_SETUP;
                end else begin
                    buf_we = 1'b1;
                    buf_wd = pfe_pkg::hex_char(dnib, r_upper);
                    n_acc  = r_s4 ? (r_acc >> 4) : (r_acc >> 3);
                    n_nd   = r_nd + 4'd1;
                end
            end
            FS_SETUP: begin
                n_zf  = zfc;
                n_cnt = cntc;
                n_pad = (7'(r_width) > cntc) ? 7'(r_width) - cntc : 7'd0;
                n_tot = ((7'(r_width) > cntc) ? 7'(r_width) : cntc);
                n_k   = 7'd0;
                n_state = (n_tot == 7'd0) ? FS_IDLE : FS_EMIT;
            end
            FS_EMIT: begin
                if (ld) begin
                    load  = 1'b1;
                    lch   = ech;
                    llast = (r_k == r_tot - 7'd1);
                    n_k   = r_k + 7'd1;
                    if (llast) n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase

        n_len    = r_len;
        n_oitem  = r_oitem;
        n_ovalid = ld ? 1'b0 : r_ovalid;
        if (load) begin
            n_ovalid = 1'b1;
            if (lfin) begin
                n_oitem.total_length = 16'(r_len);
                n_len = '0;
            end else begin
                if (r_len != pfe_pkg::LEN_MAX) n_len = r_len + 1'b1;
                n_oitem.total_length = 16'(n_len);
            end
            n_oitem.out_char    = lch;
            n_oitem.finished    = lfin;
            n_oitem.last_of_run = llast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_ovalid <= 1'b0;
            r_len    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;   r_acc <= n_acc;   r_step <= n_step; r_s4 <= n_s4;
        r_upper <= n_upper; r_octalt <= n_octalt; r_zfen <= n_zfen;
        r_left <= n_left; r_prec <= n_prec; r_width <= n_width; r_plen <= n_plen;
        r_pc0 <= n_pc0;   r_pc1 <= n_pc1;   r_nd <= n_nd;
        r_zf <= n_zf;     r_cnt <= n_cnt;   r_pad <= n_pad;   r_tot <= n_tot;
        r_k <= n_k;
        r_oitem <= n_oitem;
        if (buf_we) r_buf[buf_wa] <= buf_wd;
    end

endmodule
